### rtl/rbsk_pkg.sv
`default_nettype none

package rbsk_pkg;

    // default store depth
    localparam int MaxRecordsDefault = 8;

    // field widths
    localparam int KeyW = 16;
    localparam int TagW = 8;
    localparam int RecW = KeyW + TagW;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted record
        logic set_ovf;     // mark the set as truncated
        logic init_sort;   // set up pass limit and emit index
        logic rd_first;    // read entry 0 and restart the pass
        logic load_carry;  // take entry 0 as the carried record
        logic cmp;         // compare carry with next entry, write back the smaller
        logic wback;       // write carry to the end of the pass
        logic emit;        // read one sorted record out
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;        // store holds MAX_RECORDS records
        logic few;         // fewer than two records, nothing to sort
        logic k_last;      // this compare is the last of the pass
        logic lim_one;     // this pass was the final one
        logic e_last;      // emitting the final record
    } status_t;

endpackage

`default_nettype wire

### rtl/record_bubble_sort_by_key_top.sv
`default_nettype none

// channel   direction  handshake        payload
// records   in         start / busy     depth_key, tag, last_in
// results   out        strobe           depth_out, tag_out, last_out, truncated
//
// a record is taken in the cycle in which start is high and busy low; a set of n
// records is sorted one compare a cycle within each pass through the single store port
// pair, then read out in n beats, one a cycle, starting in the cycle after the read
// reset clears the fill count and overflow mark; store contents need no clearing
// busy stays high from the closing record until the final read is issued
// results cannot be stalled: each beat is valid for exactly one cycle
module record_bubble_sort_by_key_top #(
    parameter int MAX_RECORDS = rbsk_pkg::MaxRecordsDefault
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [rbsk_pkg::KeyW-1:0] depth_key,
    input  wire logic [rbsk_pkg::TagW-1:0] tag,
    input  wire logic                      last_in,
    output logic                           strobe,
    output logic [rbsk_pkg::KeyW-1:0]      depth_out,
    output logic [rbsk_pkg::TagW-1:0]      tag_out,
    output logic                           last_out,
    output logic                           truncated
);
    import rbsk_pkg::*;

    cmd_t    cmd;
    status_t status;

    // controller
    rbsk_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (last_in),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    // store and compare datapath
    rbsk_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .depth_key (depth_key),
        .tag       (tag),
        .status    (status),
        .strobe    (strobe),
        .depth_out (depth_out),
        .tag_out   (tag_out),
        .last_out  (last_out),
        .truncated (truncated)
    );

endmodule

`default_nettype wire

### rtl/rbsk_ctrl.sv
`default_nettype none

module rbsk_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              last_in,
    input  wire rbsk_pkg::status_t status,
    output rbsk_pkg::cmd_t         cmd,
    output logic                   busy
);
    import rbsk_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_RD0   = 7'b0000100,
        ST_CARRY = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_WBACK = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.full)
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next  = ST_PREP;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (last_in)
                        begin
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                cmd.init_sort = 1'b1;
                state_next    = status.few ? ST_EMIT : ST_RD0;
            end
            ST_RD0:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_CARRY;
            end
            ST_CARRY:
            begin
                cmd.load_carry = 1'b1;
                state_next     = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (status.k_last)
                begin
                    state_next = ST_WBACK;
                end
            end
            ST_WBACK:
            begin
                cmd.wback  = 1'b1;
                state_next = status.lim_one ? ST_EMIT : ST_RD0;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.e_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // a record is only stored while idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE) && !status.full)
        else $error("record stored outside idle or into a full store");

    // a closed set always reaches the prepare step next
    a_close_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (status.full || last_in)) |=> (state_reg == ST_PREP))
        else $error("closed set did not start sorting");

    // the sort only runs with at least two records
    a_sort_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) && status.few |=> (state_reg == ST_EMIT))
        else $error("sort entered with fewer than two records");

endmodule

`default_nettype wire

### rtl/rbsk_dp.sv
`default_nettype none

module rbsk_dp #(
    parameter int MAX_RECORDS = rbsk_pkg::MaxRecordsDefault
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rbsk_pkg::cmd_t              cmd,
    input  wire logic [rbsk_pkg::KeyW-1:0]   depth_key,
    input  wire logic [rbsk_pkg::TagW-1:0]   tag,
    output rbsk_pkg::status_t                status,
    output logic                             strobe,
    output logic [rbsk_pkg::KeyW-1:0]        depth_out,
    output logic [rbsk_pkg::TagW-1:0]        tag_out,
    output logic                             last_out,
    output logic                             truncated
);
    import rbsk_pkg::*;

    localparam int IdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CntW = $clog2(MAX_RECORDS + 1);

    // record store
    logic [RecW-1:0] mem [MAX_RECORDS];
    logic [RecW-1:0] rd_data_reg;
    logic [RecW-1:0] carry_reg;
    logic [RecW-1:0] carry_next;

    logic [CntW-1:0] count_reg;
    logic            ovf_reg;
    logic [IdxW-1:0] lim_reg;
    logic [IdxW-1:0] k_reg;
    logic [IdxW-1:0] e_reg;

    logic            strobe_reg;
    logic            last_reg;
    logic            trunc_reg;

    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [RecW-1:0] wr_data;
    logic [IdxW-1:0] rd_addr;
    logic            gt;

    // strictly greater keeps equal keys in arrival order
    assign gt = carry_reg[RecW-1:TagW] > rd_data_reg[RecW-1:TagW];

    // memory port selection
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = count_reg[IdxW-1:0];
        wr_data    = {depth_key, tag};
        rd_addr    = e_reg;
        carry_next = carry_reg;
        if (cmd.load)
        begin
            wr_en = 1'b1;
        end
        if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        if (cmd.load_carry)
        begin
            rd_addr    = k_reg + IdxW'(1);
            carry_next = rd_data_reg;
        end
        if (cmd.cmp)
        begin
            wr_en      = 1'b1;
            wr_addr    = k_reg;
            wr_data    = gt ? rd_data_reg : carry_reg;
            carry_next = gt ? carry_reg : rd_data_reg;
            rd_addr    = k_reg + IdxW'(2);
        end
        if (cmd.wback)
        begin
            wr_en   = 1'b1;
            wr_addr = lim_reg;
            wr_data = carry_reg;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        carry_reg   <= carry_next;
    end

    // fill count, overflow mark and sort indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            lim_reg   <= '0;
            k_reg     <= '0;
            e_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.init_sort)
            begin
                lim_reg <= IdxW'(count_reg - CntW'(1));
                e_reg   <= '0;
            end
            if (cmd.rd_first)
            begin
                k_reg <= '0;
            end
            if (cmd.cmp)
            begin
                k_reg <= k_reg + IdxW'(1);
            end
            if (cmd.wback)
            begin
                lim_reg <= lim_reg - IdxW'(1);
            end
            if (cmd.emit)
            begin
                e_reg <= e_reg + IdxW'(1);
                if (status.e_last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    // result beat lines up with the registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= status.e_last;
        trunc_reg <= ovf_reg;
    end

    // status
    assign status.full    = (count_reg == CntW'(MAX_RECORDS));
    assign status.few     = (count_reg < CntW'(2));
    assign status.k_last  = ((k_reg + IdxW'(1)) == lim_reg);
    assign status.lim_one = (lim_reg == IdxW'(1));
    assign status.e_last  = (e_reg == IdxW'(count_reg - CntW'(1)));

    assign strobe    = strobe_reg;
    assign depth_out = rd_data_reg[RecW-1:TagW];
    assign tag_out   = rd_data_reg[TagW-1:0];
    assign last_out  = strobe_reg & last_reg;
    assign truncated = trunc_reg;

    // fill count never passes the store depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MAX_RECORDS))
        else $error("record count beyond store depth");

    // compares stay inside the current pass
    a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> ((k_reg + IdxW'(1)) <= lim_reg))
        else $error("compare index past pass limit");

    // the final beat of a run is followed by a gap; a new set may take one record
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |=> !strobe_reg && !ovf_reg
            && (count_reg <= CntW'(1)))
        else $error("run did not close after its final beat");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import rbsk_pkg::*;

    localparam int MaxRec     = MaxRecordsDefault;
    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 80;

    // one record as the sorter holds it
    typedef struct {
        logic [KeyW-1:0] key;
        logic [TagW-1:0] tag;
    } held_rec_t;

    // one sorted beat as it leaves the block
    typedef struct {
        logic [KeyW-1:0] depth;
        logic [TagW-1:0] tag;
        logic            is_last;
        logic            trunc;
    } sorted_beat_t;

    // directed stimulus row, with a typed expectation where it is obvious
    typedef struct {
        logic [KeyW-1:0] key;
        logic [TagW-1:0] tag;
        logic            is_last;
        bit              typed;
        logic [KeyW-1:0] exp_depth;
        logic [TagW-1:0] exp_tag;
        logic            exp_last;
        logic            exp_trunc;
    } directed_row_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [KeyW-1:0] depth_key;
    logic [TagW-1:0] tag;
    logic            last_in;
    logic            strobe;
    logic [KeyW-1:0] depth_out;
    logic [TagW-1:0] tag_out;
    logic            last_out;
    logic            truncated;

    // predictor state
    held_rec_t    held_recs [MaxRec];
    int           held_count;
    bit           held_ovf;
    sorted_beat_t sorted_expect [$];

    int gap_pct;
    int records_sent;
    int sets_closed;
    int truncated_sets;
    int beats_checked;
    int mismatch_count;
    int cycles;

    // singles at the key extremes, a stable tie, a full descending set closed by
    // an overflowing record, then a full set closed by its own last mark
    directed_row_t plan [22] = '{
        '{16'hFFFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b0},
        '{16'h0000, 8'h00, 1'b1, 1'b1, 16'h0000, 8'h00, 1'b1, 1'b0},
        '{16'h0005, 8'h01, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h0005, 8'h02, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h0003, 8'h03, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'hFFFF, 8'h20, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'hF000, 8'h21, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h8001, 8'h22, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h8000, 8'h23, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h7FFF, 8'h24, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h00FF, 8'h25, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h0001, 8'h26, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h0000, 8'h27, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h1234, 8'h99, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'hAAAA, 8'h10, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h5555, 8'h11, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h8000, 8'h12, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h0001, 8'h13, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'hAAAA, 8'h14, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h7FFF, 8'h15, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'h0000, 8'h16, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{16'hFFFE, 8'h17, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0}
    };

    record_bubble_sort_by_key_top #(
        .MAX_RECORDS (MaxRec)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .depth_key (depth_key),
        .tag       (tag),
        .last_in   (last_in),
        .strobe    (strobe),
        .depth_out (depth_out),
        .tag_out   (tag_out),
        .last_out  (last_out),
        .truncated (truncated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stable bubble sort of the held set, queue every record, then empty the store
    function automatic void flush_sorted();
        held_rec_t    a;
        held_rec_t    b;
        sorted_beat_t beat;
        for (int pass = 0; pass + 1 < held_count; pass++)
        begin
            for (int k = 0; k + 1 < held_count - pass; k++)
            begin
                a = held_recs[k];
                b = held_recs[k + 1];
                if (a.key > b.key)
                begin
                    held_recs[k]     = b;
                    held_recs[k + 1] = a;
                end
            end
        end
        for (int k = 0; k < held_count; k++)
        begin
            beat.depth   = held_recs[k].key;
            beat.tag     = held_recs[k].tag;
            beat.is_last = (k + 1 == held_count);
            beat.trunc   = held_ovf;
            sorted_expect.push_back(beat);
        end
        sets_closed++;
        if (held_ovf)
            truncated_sets++;
        held_count = 0;
        held_ovf   = 1'b0;
    endfunction

    // one accepted record: store it, or drop it and close the set when full
    function automatic void absorb_record(input logic [KeyW-1:0] k,
                                          input logic [TagW-1:0] t,
                                          input logic l);
        if (held_count >= MaxRec)
        begin
            held_ovf = 1'b1;
            flush_sorted();
        end
        else
        begin
            held_recs[held_count].key = k;
            held_recs[held_count].tag = t;
            held_count++;
            if (l)
                flush_sorted();
        end
    endfunction

    // present one record, with random idle cycles ahead of it, until accepted
    task automatic send_record(input logic [KeyW-1:0] k,
                               input logic [TagW-1:0] t,
                               input logic l);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        depth_key <= k;
        tag       <= t;
        last_in   <= l;
        do
            @(posedge clk);
        while (busy);
        records_sent++;
        absorb_record(k, t, l);
    endtask

    // one random set: mostly closed by a last mark, sometimes overfilled
    task automatic random_set();
        int              n;
        int              mode;
        bit              overfill;
        logic [KeyW-1:0] k;
        overfill = ($urandom_range(0, 7) == 0);
        n        = overfill ? MaxRec : $urandom_range(1, MaxRec);
        mode     = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: k = KeyW'($urandom_range(0, 3));
                1: k = ($urandom_range(0, 1) == 1) ? '1 : '0;
                default: k = KeyW'($urandom);
            endcase
            send_record(k, TagW'($urandom), !overfill && (i == n - 1));
        end
        if (overfill)
            send_record(KeyW'($urandom), TagW'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // result checker: every strobed beat against the oldest expectation
    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && strobe)
        begin
            if (sorted_expect.size() == 0)
            begin
                $error("unexpected beat: depth_out %h tag_out %h", depth_out, tag_out);
                mismatch_count++;
            end
            else
            begin
                want = sorted_expect.pop_front();
                beats_checked++;
                if (depth_out !== want.depth)
                begin
                    $error("depth_out: expected %h, got %h", want.depth, depth_out);
                    mismatch_count++;
                end
                if (tag_out !== want.tag)
                begin
                    $error("tag_out: expected %h, got %h", want.tag, tag_out);
                    mismatch_count++;
                end
                if (last_out !== want.is_last)
                begin
                    $error("last_out: expected %b, got %b", want.is_last, last_out);
                    mismatch_count++;
                end
                if (truncated !== want.trunc)
                begin
                    $error("truncated: expected %b, got %b", want.trunc, truncated);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[record_bubble_sort_by_key_top] ERROR");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        sorted_beat_t typed_beat;
        held_count     = 0;
        held_ovf       = 1'b0;
        gap_pct        = 0;
        records_sent   = 0;
        sets_closed    = 0;
        truncated_sets = 0;
        beats_checked  = 0;
        mismatch_count = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        depth_key <= '0;
        tag       <= '0;
        last_in   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        gap_pct = 20;
        for (int i = 0; i < 22; i++)
        begin
            send_record(plan[i].key, plan[i].tag, plan[i].is_last);
            if (plan[i].typed)
            begin
                typed_beat.depth   = plan[i].exp_depth;
                typed_beat.tag     = plan[i].exp_tag;
                typed_beat.is_last = plan[i].exp_last;
                typed_beat.trunc   = plan[i].exp_trunc;
                void'(sorted_expect.pop_back());
                sorted_expect.push_back(typed_beat);
            end
        end

        // random part in idling phases: none, heavy, none again, light
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1: gap_pct = 46;
                3: gap_pct = 20;
                default: gap_pct = 0;
            endcase
            while (records_sent < 22 + 37 * (ph + 1))
                random_set();
        end
        start <= 1'b0;

        // drain
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        $display("sent %0d records in %0d sets, %0d of them truncated", records_sent,
                 sets_closed, truncated_sets);
        $display("checked %0d sorted beats, %0d mismatches", beats_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[record_bubble_sort_by_key_top] OK");
        else
            $display("[record_bubble_sort_by_key_top] ERROR");
        $finish;
    end

endmodule

### record_bubble_sort_by_key_top.f
rtl/rbsk_pkg.sv
rtl/rbsk_ctrl.sv
rtl/rbsk_dp.sv
rtl/record_bubble_sort_by_key_top.sv
sim/tb_top.sv
